>>> rtl/tisa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tisa_pkg
// Shared types and constants of the teaching ISA instruction executor.
// ----------------------------------------------------------------------------
package tisa_pkg;

    localparam int DATA_WORDS = 4096;
    localparam int MEM_AW     = $clog2(DATA_WORDS);
    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = $clog2(REG_COUNT);

    localparam int IN_W  = 56;
    localparam int OUT_W = 120;

    localparam logic [31:0] RESET_PC = 32'd4000;
    localparam logic [31:0] PC_STEP  = 32'd4;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_AND   = 4'd3,
        OP_OR    = 4'd4,
        OP_XOR   = 4'd5,
        OP_MOVC  = 4'd6,
        OP_LOAD  = 4'd7,
        OP_LDR   = 4'd8,
        OP_STORE = 4'd9,
        OP_STR   = 4'd10,
        OP_BZ    = 4'd11,
        OP_BNZ   = 4'd12,
        OP_JUMP  = 4'd13,
        OP_HALT  = 4'd14
    } t_op;

    // result of the execute stage, held in the output stage
    typedef struct packed {
        logic [31:0]       instr_pc;
        logic [31:0]       next_pc;
        logic              redirect;
        logic              reg_write;
        logic [3:0]        reg_index;
        logic [31:0]       reg_value;
        logic              is_load;
        logic              mem_write;
        logic [MEM_AW-1:0] mem_index;
        logic              stopped;
    } t_exec_res;

endpackage

>>> rtl/teaching_isa_instruction_executor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teaching_isa_instruction_executor_top
// Executes one decoded instruction per transaction against a register file,
// a word data store and a program counter, and reports what it did.
// ----------------------------------------------------------------------------
// path: an input transaction is registered into the execute stage (operand read),
//   then executed into the output stage where load data arrives
// throughput: one instruction per cycle while m_axis_tready does not stall the
//   output stage, with forwarding from the output stage into execute
// reset: after i_rst_n a clearing pass zeroes the data store and register file,
//   s_axis_tready stays low meanwhile; pc resets to 4000
module teaching_isa_instruction_executor_top
    import tisa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // cmd[3:0] dest_reg[7:4] src_a[11:8] src_b[15:12] src_c[19:16]
    // literal[51:20] zero[55:52]
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // instr_pc[31:0] next_pc[63:32] redirect[64] reg_write[65]
    // reg_index[69:66] reg_value[101:70] mem_write[102] mem_index[114:103]
    // stopped[115] zero[119:116]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic             i_cfg_valid,
    input  logic [31:0]      i_cfg_data,
    output logic             o_cfg_ready
);

    // the start address is not used; pc resets to RESET_PC, so writes are always taken
    assign o_cfg_ready = 1'b1;

    // clearing pass
    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;

    // pipeline control
    logic s1_free, s1_move, s2_adv, accept, retire;

    // execute stage
    logic              r_s1_valid;
    logic [3:0]        r_s1_cmd;
    logic [REG_AW-1:0] r_s1_rd, r_s1_ia, r_s1_ib, r_s1_ic, r_s1_ip;
    logic [31:0]       r_s1_lit;
    logic [REG_AW-1:0] r_last_dest;

    // register file, two copies with two read ports each
    logic [31:0]       r_rf0 [REG_COUNT];
    logic [31:0]       r_rf1 [REG_COUNT];
    logic [31:0]       r_rd_a, r_rd_b, r_rd_c, r_rd_p;
    logic              rf_we;
    logic [REG_AW-1:0] rf_wa;
    logic [31:0]       rf_wd;
    logic [REG_AW-1:0] in_ia, in_ib, in_ic;

    // data store
    logic [31:0]       r_dmem [DATA_WORDS];
    logic [31:0]       r_mem_rdata;
    logic              dm_we, dm_re;
    logic [MEM_AW-1:0] dm_wa;
    logic [31:0]       dm_wd;

    // architectural state
    logic [31:0] r_pc;
    logic        r_halted;

    // output stage
    logic        r_s2_valid;
    t_exec_res   r_s2;
    logic [31:0] s2_wdata;

    // execute logic
    t_exec_res   n_res;
    t_op         s1_op;
    logic [31:0] op_a, op_b, op_c, op_p;
    logic [31:0] addr_x, addr_y, addr_sum;
    logic [31:0] mul_res;

    assign s2_adv        = !r_s2_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && s2_adv;
    assign s1_free       = !r_s1_valid || s2_adv;
    assign s_axis_tready = s1_free && !r_clr_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign retire        = r_s2_valid && m_axis_tready;

    assign in_ia = s_axis_tdata[8 +: REG_AW];
    assign in_ib = s_axis_tdata[12 +: REG_AW];
    assign in_ic = s_axis_tdata[16 +: REG_AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // register file: written when the output stage retires or by the clearing pass, write-first read
    assign s2_wdata = r_s2.is_load ? r_mem_rdata : r_s2.reg_value;
    assign rf_we    = r_clr_busy || (retire && r_s2.reg_write);
    assign rf_wa    = r_clr_busy ? r_clr_addr[REG_AW-1:0] : r_s2.reg_index[REG_AW-1:0];
    assign rf_wd    = r_clr_busy ? 32'd0 : s2_wdata;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf0[rf_wa] <= rf_wd;
        end
        if (accept) begin
            r_rd_a <= (rf_we && rf_wa == in_ia) ? rf_wd : r_rf0[in_ia];
            r_rd_b <= (rf_we && rf_wa == in_ib) ? rf_wd : r_rf0[in_ib];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf1[rf_wa] <= rf_wd;
        end
        if (accept) begin
            r_rd_c <= (rf_we && rf_wa == in_ic) ? rf_wd : r_rf1[in_ic];
            r_rd_p <= (rf_we && rf_wa == r_last_dest) ? rf_wd : r_rf1[r_last_dest];
        end
    end

    // execute stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_last_dest <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (accept) begin
                r_last_dest <= s_axis_tdata[4 +: REG_AW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= s_axis_tdata[3:0];
            r_s1_rd  <= s_axis_tdata[4 +: REG_AW];
            r_s1_ia  <= in_ia;
            r_s1_ib  <= in_ib;
            r_s1_ic  <= in_ic;
            r_s1_ip  <= r_last_dest;
            r_s1_lit <= s_axis_tdata[51:20];
        end
    end

    // forward the older instruction still waiting in the output stage
    function automatic logic [31:0] fwd(
        input logic [31:0]       raw,
        input logic [REG_AW-1:0] idx,
        input logic              s2_valid,
        input t_exec_res         s2,
        input logic [31:0]       s2_val
    );
        logic hit;
        hit = s2_valid && s2.reg_write && (s2.reg_index[REG_AW-1:0] == idx);
        return hit ? s2_val : raw;
    endfunction

    assign op_a = fwd(r_rd_a, r_s1_ia, r_s2_valid, r_s2, s2_wdata);
    assign op_b = fwd(r_rd_b, r_s1_ib, r_s2_valid, r_s2, s2_wdata);
    assign op_c = fwd(r_rd_c, r_s1_ic, r_s2_valid, r_s2, s2_wdata);
    assign op_p = fwd(r_rd_p, r_s1_ip, r_s2_valid, r_s2, s2_wdata);

    assign s1_op   = t_op'(r_s1_cmd);
    assign mul_res = op_a * op_b;

    always_comb begin
        addr_x = op_a;
        addr_y = r_s1_lit;
        case (s1_op)
            OP_LDR:   begin addr_x = op_a; addr_y = op_b;     end
            OP_STORE: begin addr_x = op_b; addr_y = r_s1_lit; end
            OP_STR:   begin addr_x = op_b; addr_y = op_c;     end
            default:  begin addr_x = op_a; addr_y = r_s1_lit; end
        endcase
        addr_sum = addr_x + addr_y;
    end

    always_comb begin
        n_res           = '0;
        n_res.instr_pc  = r_pc;
        n_res.next_pc   = r_pc + PC_STEP;
        n_res.reg_index = 4'(r_s1_rd);
        if (r_halted) begin
            n_res.next_pc   = r_pc;
            n_res.reg_index = '0;
            n_res.stopped   = 1'b1;
        end else begin
            unique case (s1_op)
                OP_ADD:  begin n_res.reg_write = 1'b1; n_res.reg_value = op_a + op_b; end
                OP_SUB:  begin n_res.reg_write = 1'b1; n_res.reg_value = op_a - op_b; end
                OP_MUL:  begin n_res.reg_write = 1'b1; n_res.reg_value = mul_res;     end
                OP_AND:  begin n_res.reg_write = 1'b1; n_res.reg_value = op_a & op_b; end
                OP_OR:   begin n_res.reg_write = 1'b1; n_res.reg_value = op_a | op_b; end
                OP_XOR:  begin n_res.reg_write = 1'b1; n_res.reg_value = op_a ^ op_b; end
                OP_MOVC: begin n_res.reg_write = 1'b1; n_res.reg_value = r_s1_lit;    end
                OP_LOAD, OP_LDR: begin
                    n_res.reg_write = 1'b1;
                    n_res.is_load   = 1'b1;
                    n_res.mem_index = addr_sum[MEM_AW-1:0];
                end
                OP_STORE, OP_STR: begin
                    n_res.mem_write = 1'b1;
                    n_res.mem_index = addr_sum[MEM_AW-1:0];
                end
                OP_BZ: begin
                    if (op_p == 32'd0) begin
                        n_res.next_pc  = r_pc + r_s1_lit;
                        n_res.redirect = 1'b1;
                    end
                end
                OP_BNZ: begin
                    if (op_p != 32'd0) begin
                        n_res.next_pc  = r_pc + r_s1_lit;
                        n_res.redirect = 1'b1;
                    end
                end
                OP_JUMP: begin
                    n_res.next_pc  = op_a + r_s1_lit;
                    n_res.redirect = 1'b1;
                end
                OP_HALT: n_res.stopped = 1'b1;
                default: ;
            endcase
            if (!n_res.reg_write) begin
                n_res.reg_index = '0;
            end
        end
    end

    // data store: stores and loads both happen as the item leaves execute
    assign dm_we = r_clr_busy || (s1_move && n_res.mem_write);
    assign dm_wa = r_clr_busy ? r_clr_addr : n_res.mem_index;
    assign dm_wd = r_clr_busy ? 32'd0 : op_a;
    assign dm_re = s1_move && n_res.is_load;

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_wa] <= dm_wd;
        end
        if (dm_re) begin
            r_mem_rdata <= r_dmem[n_res.mem_index];
        end
    end

    // architectural state and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= RESET_PC;
            r_halted   <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_pc     <= n_res.next_pc;
                r_halted <= n_res.stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2 <= n_res;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {4'd0, r_s2.stopped, 12'(r_s2.mem_index), r_s2.mem_write,
                            s2_wdata, r_s2.reg_index, r_s2.reg_write, r_s2.redirect,
                            r_s2.next_pc, r_s2.instr_pc};

    // assertions
    a_no_accept_clear: assert property (@(posedge i_clk)
        r_clr_busy |-> !s_axis_tready)
        else $error("input transaction taken during clearing pass");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_pc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_pc))
        else $error("pc moved after halt");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.stopped) |-> (!r_s2.reg_write && !r_s2.mem_write && !r_s2.redirect))
        else $error("stopped instruction changed state");

    a_store_no_rf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.mem_write) |-> (!r_s2.reg_write && !r_s2.is_load))
        else $error("store also writes register file");

endmodule

>>> tb/tb_teaching_isa_instruction_executor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_teaching_isa_instruction_executor_top
// Self-checking bench for the teaching ISA executor. A queue of decoded
// instructions feeds a stream driver; every accepted instruction is run
// through an instruction-level model of the core (registers, data store, pc,
// last destination, halt) and the result transaction is compared field by
// field. Directed corner cases come first, then four pacing phases of random
// store/load, compare/branch and noise sequences, then halt and a frozen tail.
// ----------------------------------------------------------------------------
module tb_teaching_isa_instruction_executor_top;
    import tisa_pkg::*;

    localparam int          CLK_HALF   = 5;
    localparam int          CYCLE_CAP  = 300000;
    localparam int          STALL_LEN  = 400;
    localparam int          PHASE_LEN  = 405;
    localparam logic [3:0]  CMD_UNDEF  = 4'd15;

    typedef struct {
        logic [3:0]  cmd;
        logic [3:0]  rd;
        logic [3:0]  rs1;
        logic [3:0]  rs2;
        logic [3:0]  rs3;
        logic [31:0] imm;
    } instr_t;

    typedef struct {
        logic [31:0]       instr_pc;
        logic [31:0]       next_pc;
        logic              redirect;
        logic              reg_write;
        logic [3:0]        reg_index;
        logic [31:0]       reg_value;
        logic              mem_write;
        logic [MEM_AW-1:0] mem_index;
        logic              stopped;
    } retire_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [31:0]       i_cfg_data = '0;
    logic              o_cfg_ready;

    // core model state
    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] data_mem [DATA_WORDS];
    logic [31:0] arch_pc;
    logic [3:0]  last_dest;
    logic        halted;
    logic [31:0] start_addr_cfg;

    instr_t  pending_instrs[$];
    retire_t expected_retires[$];

    int n_queued = 0;
    int n_sent = 0;
    int n_taken = 0;
    int n_checked = 0;
    int n_redirects = 0;
    int n_mem_writes = 0;
    int n_cfg_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    bit stall_req = 1'b0;
    bit stall_done = 1'b0;
    int stall_cycles = 0;

    teaching_isa_instruction_executor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_retires.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [3:0] rand_reg();
        return 4'($urandom_range(0, REG_COUNT - 1));
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 128)) - 32'd64;
            1: return 32'($urandom_range(0, 32)) * PC_STEP - 32'd64;
            // near the store wrap boundary
            2: return 32'(DATA_WORDS) * $urandom_range(0, 3) - 32'($urandom_range(0, 8));
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t mk(logic [3:0] cmd, logic [3:0] rd, logic [3:0] rs1,
                                  logic [3:0] rs2, logic [3:0] rs3, logic [31:0] imm);
        instr_t ins;
        ins.cmd = cmd;
        ins.rd  = rd;
        ins.rs1 = rs1;
        ins.rs2 = rs2;
        ins.rs3 = rs3;
        ins.imm = imm;
        return ins;
    endfunction

    function automatic logic [IN_W-1:0] pack_instr(instr_t ins);
        return {4'b0, ins.imm, ins.rs3, ins.rs2, ins.rs1, ins.rd, ins.cmd};
    endfunction

    function automatic logic [MEM_AW-1:0] word_idx(logic [31:0] addr);
        return MEM_AW'(addr % DATA_WORDS);
    endfunction

    function automatic void reset_core();
        for (int k = 0; k < REG_COUNT; k++) arch_regs[k] = '0;
        for (int k = 0; k < DATA_WORDS; k++) data_mem[k] = '0;
        start_addr_cfg = RESET_PC;
        arch_pc = RESET_PC;
        last_dest = '0;
        halted = 1'b0;
    endfunction

    // executes one instruction on the model and returns what the core reports
    function automatic retire_t execute_instr(instr_t ins);
        retire_t r;
        logic [31:0] a, b, c;
        a = arch_regs[ins.rs1 % REG_COUNT];
        b = arch_regs[ins.rs2 % REG_COUNT];
        c = arch_regs[ins.rs3 % REG_COUNT];
        r.instr_pc  = arch_pc;
        r.next_pc   = arch_pc + PC_STEP;
        r.redirect  = 1'b0;
        r.reg_write = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        r.mem_write = 1'b0;
        r.mem_index = '0;
        r.stopped   = 1'b1;
        if (halted) begin
            r.next_pc = arch_pc;
            return r;
        end
        case (ins.cmd)
            OP_ADD:  begin r.reg_write = 1'b1; r.reg_value = a + b; end
            OP_SUB:  begin r.reg_write = 1'b1; r.reg_value = a - b; end
            OP_MUL:  begin r.reg_write = 1'b1; r.reg_value = a * b; end
            OP_AND:  begin r.reg_write = 1'b1; r.reg_value = a & b; end
            OP_OR:   begin r.reg_write = 1'b1; r.reg_value = a | b; end
            OP_XOR:  begin r.reg_write = 1'b1; r.reg_value = a ^ b; end
            OP_MOVC: begin r.reg_write = 1'b1; r.reg_value = ins.imm; end
            OP_LOAD: begin
                r.mem_index = word_idx(a + ins.imm);
                r.reg_write = 1'b1;
                r.reg_value = data_mem[r.mem_index];
            end
            OP_LDR: begin
                r.mem_index = word_idx(a + b);
                r.reg_write = 1'b1;
                r.reg_value = data_mem[r.mem_index];
            end
            OP_STORE: begin
                r.mem_index = word_idx(b + ins.imm);
                r.mem_write = 1'b1;
                data_mem[r.mem_index] = a;
            end
            OP_STR: begin
                r.mem_index = word_idx(b + c);
                r.mem_write = 1'b1;
                data_mem[r.mem_index] = a;
            end
            OP_BZ: begin
                if (arch_regs[last_dest % REG_COUNT] == '0) begin
                    r.next_pc = arch_pc + ins.imm;
                    r.redirect = 1'b1;
                end
            end
            OP_BNZ: begin
                if (arch_regs[last_dest % REG_COUNT] != '0) begin
                    r.next_pc = arch_pc + ins.imm;
                    r.redirect = 1'b1;
                end
            end
            OP_JUMP: begin r.next_pc = a + ins.imm; r.redirect = 1'b1; end
            OP_HALT: halted = 1'b1;
            default: ;
        endcase
        if (r.reg_write) begin
            r.reg_index = ins.rd;
            arch_regs[ins.rd % REG_COUNT] = r.reg_value;
        end
        last_dest = ins.rd;
        arch_pc = r.next_pc;
        r.stopped = halted;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("result %0d field %s: expected %h, got %h", n_checked, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // input driver: presents the next instruction once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || n_taken == n_sent)) begin
            if (pending_instrs.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                s_axis_tdata  <= pack_instr(pending_instrs.pop_front());
                s_axis_tvalid <= 1'b1;
                n_sent++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the pipeline
    always @(negedge i_clk) begin
        if (stall_req && !stall_done) begin
            m_axis_tready <= 1'b0;
            stall_cycles++;
            if (stall_cycles >= STALL_LEN) stall_done = 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        retire_t exp_r;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                instr_t ins;
                ins.cmd = s_axis_tdata[3:0];
                ins.rd  = s_axis_tdata[7:4];
                ins.rs1 = s_axis_tdata[11:8];
                ins.rs2 = s_axis_tdata[15:12];
                ins.rs3 = s_axis_tdata[19:16];
                ins.imm = s_axis_tdata[51:20];
                expected_retires.push_back(execute_instr(ins));
                n_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_retires.size() == 0) begin
                    $error("result with no instruction outstanding: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_r = expected_retires.pop_front();
                    check_field("instr_pc",  exp_r.instr_pc,  m_axis_tdata[31:0]);
                    check_field("next_pc",   exp_r.next_pc,   m_axis_tdata[63:32]);
                    check_field("redirect",  exp_r.redirect,  m_axis_tdata[64]);
                    check_field("reg_write", exp_r.reg_write, m_axis_tdata[65]);
                    check_field("reg_index", exp_r.reg_index, m_axis_tdata[69:66]);
                    check_field("reg_value", exp_r.reg_value, m_axis_tdata[101:70]);
                    check_field("mem_write", exp_r.mem_write, m_axis_tdata[102]);
                    check_field("mem_index", exp_r.mem_index, m_axis_tdata[114:103]);
                    check_field("stopped",   exp_r.stopped,   m_axis_tdata[115]);
                    if (exp_r.redirect) n_redirects++;
                    if (exp_r.mem_write) n_mem_writes++;
                    n_checked++;
                end
            end
        end
    end

    task automatic queue_instr(instr_t ins);
        pending_instrs.push_back(ins);
        n_queued++;
    endtask

    // well-formed sequences with random content, plus some noise
    task automatic queue_sequence();
        logic [3:0]  base, val, dst, off_reg, tmp;
        logic [31:0] off;
        base = rand_reg();
        val = rand_reg();
        dst = rand_reg();
        off_reg = rand_reg();
        tmp = rand_reg();
        off = 32'($urandom_range(0, 32)) - 32'd16;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                queue_instr(mk(OP_MOVC, base, rand_reg(), rand_reg(), rand_reg(),
                               32'($urandom_range(0, 64))));
                if ($urandom_range(0, 1)) begin
                    queue_instr(mk(OP_STORE, rand_reg(), val, base, rand_reg(), off));
                    if ($urandom_range(0, 3) == 0)
                        queue_instr(mk(4'($urandom_range(0, 5)), dst, rand_reg(), rand_reg(),
                                       rand_reg(), rand_imm()));
                    queue_instr(mk(OP_LOAD, dst, base, rand_reg(), rand_reg(), off));
                end else begin
                    queue_instr(mk(OP_MOVC, off_reg, rand_reg(), rand_reg(), rand_reg(), off));
                    queue_instr(mk(OP_STR, rand_reg(), val, base, off_reg, rand_imm()));
                    queue_instr(mk(OP_LDR, dst, base, off_reg, rand_reg(), rand_imm()));
                end
            end
            4, 5, 6: begin
                // compare then branch on the compare's destination
                if ($urandom_range(0, 1))
                    queue_instr(mk(OP_SUB, tmp, val, val, rand_reg(), rand_imm()));
                else
                    queue_instr(mk(4'($urandom_range(0, 6)), tmp, rand_reg(), rand_reg(),
                                   rand_reg(), rand_imm()));
                queue_instr(mk($urandom_range(0, 1) ? OP_BZ : OP_BNZ, rand_reg(), rand_reg(),
                               rand_reg(), rand_reg(), rand_imm()));
            end
            default: begin
                instr_t ins;
                ins = mk(4'($urandom_range(0, 13)), rand_reg(), rand_reg(), rand_reg(),
                         rand_reg(), rand_imm());
                if ($urandom_range(0, 24) == 0) ins.cmd = CMD_UNDEF;
                queue_instr(ins);
            end
        endcase
    endtask

    task automatic wait_idle();
        while (pending_instrs.size() != 0 || n_taken != n_sent || expected_retires.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_addr(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // the core does not use the start address, so the running pc is kept
        start_addr_cfg = value;
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        reset_core();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_start_addr(32'h0000_0000);

        // extremes of the operands and the address wrap
        queue_instr(mk(OP_MOVC, 4'd1, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF));
        queue_instr(mk(OP_MOVC, 4'd2, 4'd15, 4'd15, 4'd15, 32'h8000_0000));
        queue_instr(mk(OP_MOVC, 4'd15, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF));
        queue_instr(mk(OP_ADD, 4'd3, 4'd1, 4'd2, 4'd0, 32'h0));
        queue_instr(mk(OP_SUB, 4'd4, 4'd2, 4'd1, 4'd0, 32'h0));
        queue_instr(mk(OP_MUL, 4'd5, 4'd1, 4'd1, 4'd0, 32'h0));
        queue_instr(mk(OP_AND, 4'd6, 4'd15, 4'd1, 4'd0, 32'h0));
        queue_instr(mk(OP_OR, 4'd7, 4'd1, 4'd2, 4'd0, 32'h0));
        queue_instr(mk(OP_XOR, 4'd8, 4'd15, 4'd1, 4'd0, 32'h0));
        queue_instr(mk(OP_STORE, 4'd0, 4'd15, 4'd0, 4'd0, 32'(DATA_WORDS - 1)));
        queue_instr(mk(OP_LOAD, 4'd9, 4'd0, 4'd0, 4'd0, 32'(DATA_WORDS - 1)));
        // address wraps past the top of the 32-bit space
        queue_instr(mk(OP_STORE, 4'd0, 4'd1, 4'd15, 4'd0, 32'h1));
        queue_instr(mk(OP_LDR, 4'd10, 4'd15, 4'd0, 4'd0, 32'h0));
        queue_instr(mk(OP_STR, 4'd0, 4'd2, 4'd1, 4'd1, 32'h0));
        queue_instr(mk(OP_LDR, 4'd0, 4'd1, 4'd1, 4'd0, 32'h0));
        // branch on a zero last destination, then on a nonzero one
        queue_instr(mk(OP_MOVC, 4'd11, 4'd0, 4'd0, 4'd0, 32'h0));
        queue_instr(mk(OP_BZ, 4'd15, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFF8));
        queue_instr(mk(OP_BNZ, 4'd11, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF));
        queue_instr(mk(OP_BNZ, 4'd15, 4'd0, 4'd0, 4'd0, 32'h8000_0000));
        queue_instr(mk(OP_BZ, 4'd0, 4'd0, 4'd0, 4'd0, 32'h10));
        queue_instr(mk(OP_JUMP, 4'd0, 4'd15, 4'd0, 4'd0, 32'h1));
        queue_instr(mk(OP_JUMP, 4'd15, 4'd1, 4'd0, 4'd0, 32'h8000_0000));
        queue_instr(mk(CMD_UNDEF, 4'd15, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF));
        wait_idle();
        write_start_addr(32'hFFFF_FFFF);

        for (int phase = 0; phase < 4; phase++) begin
            int phase_end;
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  stall_req = 1'b1; end
                1: begin in_idle_pct = 82; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 82; end
                default: begin in_idle_pct = 22; out_stall_pct = 22; end
            endcase
            phase_end = n_queued + PHASE_LEN;
            while (n_queued < phase_end) queue_sequence();
            wait_idle();
            write_start_addr(phase == 3 ? RESET_PC : $urandom);
        end

        // halt, then a frozen tail
        in_idle_pct = 22;
        out_stall_pct = 22;
        queue_instr(mk(OP_HALT, rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_imm()));
        for (int k = 0; k < 5; k++)
            queue_instr(mk(4'($urandom_range(0, 15)), rand_reg(), rand_reg(), rand_reg(),
                           rand_reg(), $urandom));
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("%0d instructions executed, %0d results checked (%0d redirects, %0d stores)",
                 n_taken, n_checked, n_redirects, n_mem_writes);
        $display("4 pacing phases with a %0d-cycle output hold-off, %0d start address writes",
                 STALL_LEN, n_cfg_writes);
        if (mismatches == 0 && expected_retires.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> teaching_isa_instruction_executor_top.f
rtl/tisa_pkg.sv
rtl/teaching_isa_instruction_executor_top.sv
tb/tb_teaching_isa_instruction_executor_top.sv
